[src/stmm_pkg.sv]
// Shared types and constants for the sparse table range min/max engine.
`timescale 1ns / 1ps

package stmm_pkg;

	localparam int VALUE_BITS = 32;
	localparam int INDEX_BITS = 10;

	// Request kinds carried on the input tuser bit
	localparam logic REQ_LOAD = 1'b0;

	typedef enum logic [1:0] {
		OP_NONE,
		OP_LOAD,
		OP_QUERY,
		OP_BUILD
	} op_t;

	typedef struct packed {
		op_t  op;
		logic result_load;
	} dp_cmd_t;

	typedef struct packed {
		logic out_free;
	} dp_status_t;

endpackage

[src/sparse_table_range_min_max.sv]
// Top level of the sparse table range minimum/maximum query engine.
`timescale 1ns / 1ps

// Channel   Dir  Beat contents (low bits first)
// s_*       in   tuser=req_type, tlast=load_last,
//                tdata=elem_value[31:0], left_index[41:32], right_index[51:42], zero pad
// m_*       out  tuser=range_error, tdata=span_min[31:0], span_max[63:32]
//
// A load beat writes level 0 of both tables through the single write port.
// A query beat sends its addresses to the two table read ports on the accept cycle, and
// the registered read data is combined and loaded into the output register once it is free.
// The load beat with tlast set starts a build that blocks input: each level has a setup step,
// one pair read per cycle and an end-of-level step, and a final step closes the build.
// Reset clears the controller state, count, pointer and build walk, and the output valid;
// tables hold garbage until built, with no clearing pass.
// A result waiting on m_tready does not stop the next beat from being accepted; a following
// query then holds in its compare cycle until the output register frees.

module sparse_table_range_min_max import stmm_pkg::*; #(
	parameter int MAX_ELEMENTS = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,   // elem_value[31:0], left_index[41:32], right_index[51:42]
	input  logic        s_tuser,   // req_type
	input  logic        s_tlast,   // load_last
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // span_min[31:0], span_max[63:32]
	output logic        m_tuser    // range_error
);

	localparam int IW     = $clog2(MAX_ELEMENTS);
	localparam int CW     = $clog2(MAX_ELEMENTS + 1);
	localparam int LAW    = $clog2(IW + 1);

	dp_cmd_t        cmd;
	dp_status_t     status;
	logic [IW-1:0]  wr_ptr;
	logic [CW-1:0]  elem_count;
	logic [LAW-1:0] build_lvl;
	logic [IW-1:0]  build_idx;

	logic signed [VALUE_BITS-1:0] span_min, span_max;

	stmm_ctrl #(
		.MAX_ELEMENTS(MAX_ELEMENTS)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.req_type   (s_tuser),
		.load_last  (s_tlast),
		.cmd        (cmd),
		.status     (status),
		.wr_ptr     (wr_ptr),
		.elem_count (elem_count),
		.build_lvl  (build_lvl),
		.build_idx  (build_idx)
	);

	stmm_dp #(
		.MAX_ELEMENTS(MAX_ELEMENTS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.elem_value  (s_tdata[VALUE_BITS-1:0]),
		.left_index  (s_tdata[VALUE_BITS +: INDEX_BITS]),
		.right_index (s_tdata[VALUE_BITS+INDEX_BITS +: INDEX_BITS]),
		.wr_ptr      (wr_ptr),
		.elem_count  (elem_count),
		.build_lvl   (build_lvl),
		.build_idx   (build_idx),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.span_min    (span_min),
		.span_max    (span_max),
		.range_error (m_tuser)
	);

	assign m_tdata = {span_max, span_min};

endmodule

[src/stmm_ctrl.sv]
// Controller: request sequencing, load pointer, element count and build walk.
`timescale 1ns / 1ps

module stmm_ctrl import stmm_pkg::*; #(
	parameter int MAX_ELEMENTS = 1024
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              req_type,
	input  logic                              load_last,
	output dp_cmd_t                           cmd,
	input  dp_status_t                        status,
	output logic [$clog2(MAX_ELEMENTS)-1:0]   wr_ptr,
	output logic [$clog2(MAX_ELEMENTS+1)-1:0] elem_count,
	output logic [$clog2($clog2(MAX_ELEMENTS)+1)-1:0] build_lvl,
	output logic [$clog2(MAX_ELEMENTS)-1:0]   build_idx
);

	localparam int IW     = $clog2(MAX_ELEMENTS);
	localparam int CW     = $clog2(MAX_ELEMENTS + 1);
	localparam int PW     = CW + 1;
	localparam int LEVELS = IW + 1;
	localparam int LAW    = $clog2(LEVELS);
	localparam int JW     = $clog2(LEVELS + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_QRY_CMP,
		ST_BLD_RUN,
		ST_BLD_GAP
	} state_t;

	state_t        state_q;
	logic [CW-1:0] wp_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] idx_q;
	logic [JW-1:0] lvl_q;

	logic          accept;
	logic          has_room;
	logic [CW-1:0] wp_next;
	logic [PW-1:0] win_len;
	logic          lvl_fits;
	logic          win_fits;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign has_room = wp_q < CW'(MAX_ELEMENTS);
	assign wp_next  = has_room ? wp_q + CW'(1) : wp_q;
	assign win_len  = PW'(1) << lvl_q;
	assign lvl_fits = win_len <= PW'(cnt_q);
	assign win_fits = (PW'(idx_q) + win_len) <= PW'(cnt_q);

	assign wr_ptr     = wp_q[IW-1:0];
	assign elem_count = cnt_q;
	assign build_lvl  = lvl_q[LAW-1:0];
	assign build_idx  = idx_q[IW-1:0];

	always_comb begin
		cmd.op          = OP_NONE;
		cmd.result_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (req_type == REQ_LOAD) begin
						if (has_room) cmd.op = OP_LOAD;
					end else begin
						cmd.op = OP_QUERY;
					end
				end
			end
			ST_QRY_CMP: begin
				cmd.result_load = status.out_free;
			end
			ST_BLD_RUN: begin
				if (win_fits) cmd.op = OP_BUILD;
			end
			ST_BLD_GAP: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			wp_q    <= '0;
			cnt_q   <= '0;
			idx_q   <= '0;
			lvl_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (req_type == REQ_LOAD) begin
							if (load_last) begin
								cnt_q   <= wp_next;
								wp_q    <= '0;
								lvl_q   <= JW'(1);
								state_q <= ST_BLD_GAP;
							end else begin
								cnt_q <= '0;
								wp_q  <= wp_next;
							end
						end else begin
							state_q <= ST_QRY_CMP;
						end
					end
				end
				ST_QRY_CMP: begin
					if (status.out_free) state_q <= ST_IDLE;
				end
				ST_BLD_RUN: begin
					if (win_fits) begin
						idx_q <= idx_q + CW'(1);
					end else begin
						lvl_q   <= lvl_q + JW'(1);
						state_q <= ST_BLD_GAP;
					end
				end
				ST_BLD_GAP: begin
					// gap state between levels: the last write of the previous level lands before the next level reads
					idx_q   <= '0;
					state_q <= lvl_fits ? ST_BLD_RUN : ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

[src/stmm_dp.sv]
// Datapath: level tables, address generation, min/max combine and result register.
`timescale 1ns / 1ps

module stmm_dp import stmm_pkg::*; #(
	parameter int MAX_ELEMENTS = 1024
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  dp_cmd_t                           cmd,
	output dp_status_t                        status,
	input  logic signed [VALUE_BITS-1:0]      elem_value,
	input  logic [INDEX_BITS-1:0]             left_index,
	input  logic [INDEX_BITS-1:0]             right_index,
	input  logic [$clog2(MAX_ELEMENTS)-1:0]   wr_ptr,
	input  logic [$clog2(MAX_ELEMENTS+1)-1:0] elem_count,
	input  logic [$clog2($clog2(MAX_ELEMENTS)+1)-1:0] build_lvl,
	input  logic [$clog2(MAX_ELEMENTS)-1:0]   build_idx,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [VALUE_BITS-1:0]      span_min,
	output logic signed [VALUE_BITS-1:0]      span_max,
	output logic                              range_error
);

	localparam int IW     = $clog2(MAX_ELEMENTS);
	localparam int LEVELS = IW + 1;
	localparam int LAW    = $clog2(LEVELS);
	localparam int DEPTH  = LEVELS << IW;
	localparam int AW     = $clog2(DEPTH);
	localparam int QW     = ((IW > INDEX_BITS) ? IW : INDEX_BITS) + 1;

	logic signed [VALUE_BITS-1:0] min_mem [DEPTH];
	logic signed [VALUE_BITS-1:0] max_mem [DEPTH];

	logic signed [VALUE_BITS-1:0] min_a_q, min_b_q, max_a_q, max_b_q;
	logic signed [VALUE_BITS-1:0] comb_min, comb_max;

	logic          err_s1;
	logic          bld_wr_s1;
	logic [AW-1:0] bld_addr_s1;
	logic          out_valid_q;

	// query addressing
	logic [QW-1:0]  lx, rx, span_len, tail_start;
	logic [LAW-1:0] q_lvl;
	logic           q_err;

	// build addressing
	logic [LAW-1:0] prev_lvl;
	logic [IW:0]    half, pair_idx;

	logic          rd_en, we;
	logic [AW-1:0] ra, rb, wa;
	logic signed [VALUE_BITS-1:0] wd_min, wd_max;

	always_comb begin
		lx       = QW'(left_index);
		rx       = QW'(right_index);
		span_len = rx - lx + QW'(1);
		q_err    = (lx > rx) || (rx >= QW'(elem_count));
		q_lvl    = '0;
		for (int k = 0; k < QW; k++) begin
			if (span_len[k]) q_lvl = LAW'(k);
		end
		tail_start = rx + QW'(1) - (QW'(1) << q_lvl);
	end

	assign prev_lvl = build_lvl - LAW'(1);
	assign half     = (IW+1)'(1) << prev_lvl;
	assign pair_idx = (IW+1)'(build_idx) + half;

	always_comb begin
		rd_en = 1'b0;
		ra    = '0;
		rb    = '0;
		case (cmd.op)
			OP_QUERY: begin
				rd_en = 1'b1;
				ra    = AW'({q_lvl, lx[IW-1:0]});
				rb    = AW'({q_lvl, tail_start[IW-1:0]});
			end
			OP_BUILD: begin
				rd_en = 1'b1;
				ra    = AW'({prev_lvl, build_idx});
				rb    = AW'({prev_lvl, pair_idx[IW-1:0]});
			end
			default: begin
			end
		endcase
	end

	assign comb_min = (min_b_q < min_a_q) ? min_b_q : min_a_q;
	assign comb_max = (max_b_q > max_a_q) ? max_b_q : max_a_q;

	// build writes have priority; loads never overlap a build
	always_comb begin
		if (bld_wr_s1) begin
			we     = 1'b1;
			wa     = bld_addr_s1;
			wd_min = comb_min;
			wd_max = comb_max;
		end else begin
			we     = (cmd.op == OP_LOAD);
			wa     = AW'({LAW'(0), wr_ptr});
			wd_min = elem_value;
			wd_max = elem_value;
		end
	end

	always_ff @(posedge clk) begin
		if (we) min_mem[wa] <= wd_min;
		if (rd_en) begin
			min_a_q <= min_mem[ra];
			min_b_q <= min_mem[rb];
		end
	end

	always_ff @(posedge clk) begin
		if (we) max_mem[wa] <= wd_max;
		if (rd_en) begin
			max_a_q <= max_mem[ra];
			max_b_q <= max_mem[rb];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bld_wr_s1   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			bld_wr_s1 <= (cmd.op == OP_BUILD);
			if (cmd.result_load) out_valid_q <= 1'b1;
			else if (out_ready)  out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		bld_addr_s1 <= AW'({build_lvl, build_idx});
		if (cmd.op == OP_QUERY) err_s1 <= q_err;
		if (cmd.result_load) begin
			range_error <= err_s1;
			span_min    <= err_s1 ? '0 : comb_min;
			span_max    <= err_s1 ? '0 : comb_max;
		end
	end

	assign out_valid       = out_valid_q;
	assign status.out_free = !out_valid_q || out_ready;

endmodule

[tb/sv/span_minmax_checker.sv]
// Checker for the range min/max engine: watches both channels, predicts each query answer, compares.
`timescale 1ns / 1ps

module span_minmax_checker import stmm_pkg::*; #(
	parameter int MAX_ELEMENTS = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [55:0] s_tdata,   // elem_value[31:0], left_index[41:32], right_index[51:42]
	input  logic        s_tuser,   // req_type
	input  logic        s_tlast,   // load_last
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [63:0] m_tdata,   // span_min[31:0], span_max[63:32]
	input  logic        m_tuser,   // range_error
	output int          fail_count,
	output int          pending
);

	typedef struct packed {
		logic signed [VALUE_BITS-1:0] lo;
		logic signed [VALUE_BITS-1:0] hi;
		logic                         err;
	} span_answer_t;

	// Level 0 is all that is needed: the min/max over a span equals the min/max of its elements.
	logic signed [VALUE_BITS-1:0] elem_mem [MAX_ELEMENTS];
	int unsigned  live_count;
	int unsigned  fill_ptr;
	int           mistakes;
	span_answer_t answer_q[$];

	always @(posedge clk or negedge arst_n) begin : watch
		span_answer_t                 want;
		logic signed [VALUE_BITS-1:0] lo;
		logic signed [VALUE_BITS-1:0] hi;
		int unsigned                  left;
		int unsigned                  right;
		if (!arst_n) begin
			live_count = 0;
			fill_ptr   = 0;
			mistakes   = 0;
			answer_q.delete();
			pending    <= 0;
			fail_count <= 0;
		end else begin
			// Results first: an answer leaving now always belongs to an earlier query.
			if (m_tvalid && m_tready) begin
				if (answer_q.size() == 0) begin
					$display("%0t: unexpected result: expected none, actual min %0d max %0d err %0b",
						$time, $signed(m_tdata[VALUE_BITS-1:0]),
						$signed(m_tdata[2*VALUE_BITS-1:VALUE_BITS]), m_tuser);
					mistakes++;
				end else begin
					want = answer_q.pop_front();
					if (m_tdata[VALUE_BITS-1:0] !== want.lo) begin
						$display("%0t: span_min mismatch: expected %0d actual %0d", $time,
							want.lo, $signed(m_tdata[VALUE_BITS-1:0]));
						mistakes++;
					end
					if (m_tdata[2*VALUE_BITS-1:VALUE_BITS] !== want.hi) begin
						$display("%0t: span_max mismatch: expected %0d actual %0d", $time,
							want.hi, $signed(m_tdata[2*VALUE_BITS-1:VALUE_BITS]));
						mistakes++;
					end
					if (m_tuser !== want.err) begin
						$display("%0t: range_error mismatch: expected %0b actual %0b", $time,
							want.err, m_tuser);
						mistakes++;
					end
				end
			end

			if (s_tvalid && s_tready) begin
				if (s_tuser == REQ_LOAD) begin
					// any load voids the count until its batch closes
					live_count = 0;
					if (fill_ptr < MAX_ELEMENTS) begin
						elem_mem[fill_ptr] = s_tdata[VALUE_BITS-1:0];
						fill_ptr++;
					end
					if (s_tlast) begin
						live_count = fill_ptr;
						fill_ptr   = 0;
					end
				end else begin
					left  = s_tdata[VALUE_BITS +: INDEX_BITS];
					right = s_tdata[VALUE_BITS+INDEX_BITS +: INDEX_BITS];
					want  = '0;
					if (left > right || right >= live_count) begin
						want.err = 1'b1;
					end else begin
						lo = elem_mem[left];
						hi = lo;
						for (int unsigned i = left + 1; i <= right; i++) begin
							if (elem_mem[i] < lo) lo = elem_mem[i];
							if (elem_mem[i] > hi) hi = elem_mem[i];
						end
						want.lo = lo;
						want.hi = hi;
					end
					answer_q.push_back(want);
				end
			end

			pending    <= answer_q.size();
			fail_count <= mistakes;
		end
	end

endmodule

[tb/sv/testbench.sv]
// Testbench top: drives load and query beats into the range min/max engine and gives the verdict.
`timescale 1ns / 1ps

module testbench;
	import stmm_pkg::*;

	localparam int   MAX_ELEMENTS = 1024;
	localparam int   RANDOM_ITEMS = 1500;
	localparam int   CYCLE_LIMIT  = 400_000;
	// Wide margin waited past the last answer before the verdict.
	localparam int   DRAIN_CYCLES = 16;
	localparam int   PAD_BITS     = 56 - VALUE_BITS - 2 * INDEX_BITS;
	localparam logic REQ_QUERY    = ~REQ_LOAD;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [55:0] s_tdata;   // elem_value[31:0], left_index[41:32], right_index[51:42]
	logic        s_tuser;   // req_type
	logic        s_tlast;   // load_last
	logic        m_tvalid;
	logic        m_tready;
	logic [63:0] m_tdata;   // span_min[31:0], span_max[63:32]
	logic        m_tuser;   // range_error

	int          fail_count;
	int          pending;
	int          cycle_count;
	int          beats_sent;
	int          live_count;   // count the engine will hold once the current batch closes
	logic        steady;       // high: neither side idles

	sparse_table_range_min_max #(
		.MAX_ELEMENTS(MAX_ELEMENTS)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.s_tlast (s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	span_minmax_checker #(
		.MAX_ELEMENTS(MAX_ELEMENTS)
	) u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.fail_count(fail_count),
		.pending   (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog: a hung handshake or a lost answer ends here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("sparse_table_range_min_max test failed");
			$finish;
		end
	end

	// Result side: stall about 22% of cycles, never inside the steady stretch.
	always @(posedge clk) begin
		m_tready <= steady || ($urandom_range(0, 99) >= 22);
	end

	// Edge values, small values around zero, and plain random words.
	function automatic logic [VALUE_BITS-1:0] pick_value();
		case ($urandom_range(0, 9))
			0:       return 32'h8000_0000;
			1:       return 32'h7FFF_FFFF;
			2:       return $urandom_range(0, 8) - 32'd4;
			default: return $urandom;
		endcase
	endfunction

	// One beat on the input channel. Called at a clock edge, returns at the accepting edge
	// with tvalid still high, so back-to-back beats never lower and raise it in one step.
	task automatic push_beat(input logic kind, input logic [VALUE_BITS-1:0] value,
		input logic last, input logic [INDEX_BITS-1:0] left,
		input logic [INDEX_BITS-1:0] right);
		if (!steady && $urandom_range(0, 99) < 22) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tlast  <= last;
		s_tdata  <= {{PAD_BITS{1'b0}}, right, left, value};
		do @(posedge clk); while (!s_tready);
		beats_sent++;
	endtask

	// Query with junk in the fields a query ignores.
	task automatic ask_span(input int unsigned left, input int unsigned right);
		push_beat(REQ_QUERY, $urandom, $urandom_range(0, 1), INDEX_BITS'(left),
			INDEX_BITS'(right));
	endtask

	// Load batch closed by tlast; optionally sprinkle queries inside it, which error after its first load.
	task automatic load_run(input int len, input logic mixed);
		for (int i = 0; i < len; i++) begin
			if (mixed && $urandom_range(0, 19) == 0)
				ask_span($urandom_range(0, 1023), $urandom_range(0, 1023));
			push_beat(REQ_LOAD, pick_value(), i == len - 1, INDEX_BITS'($urandom),
				INDEX_BITS'($urandom));
		end
		live_count = (len > MAX_ELEMENTS) ? MAX_ELEMENTS : len;
	endtask

	// Mostly in-range spans of assorted shapes; some noise across the whole index space.
	task automatic ask_random_span();
		int unsigned left;
		int unsigned right;
		if ($urandom_range(0, 99) < 15) begin
			left  = $urandom_range(0, 1023);
			right = $urandom_range(0, 1023);
		end else begin
			case ($urandom_range(0, 5))
				0: begin
					left  = $urandom_range(0, live_count - 1);
					right = left;
				end
				1: begin
					left  = 0;
					right = live_count - 1;
				end
				2: begin
					right = live_count - 1;
					left  = $urandom_range(0, right);
				end
				3: begin
					left  = $urandom_range(0, live_count - 1);
					right = left + $urandom_range(0, 3);
					if (right > live_count - 1) right = live_count - 1;
				end
				default: begin
					left  = $urandom_range(0, live_count - 1);
					right = $urandom_range(left, live_count - 1);
				end
			endcase
		end
		ask_span(left, right);
	endtask

	// Drop tvalid and wait until every expected answer is back. The checker's count
	// is registered, hence the edge before the first look.
	task automatic drain_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	initial begin : stimulus
		logic [VALUE_BITS-1:0] corner_vals [8];
		int                    base;
		int                    big_len;
		int                    batch_len;
		logic                  big_done;

		s_tvalid    <= 1'b0;
		s_tdata     <= '0;
		s_tuser     <= REQ_LOAD;
		s_tlast     <= 1'b0;
		m_tready    <= 1'b0;
		arst_n      <= 1'b0;
		steady      <= 1'b0;
		cycle_count <= 0;
		beats_sent  = 0;
		live_count  = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// --- directed ---
		// nothing loaded yet: both must error, including a reversed span
		ask_span(0, 0);
		ask_span(5, 3);

		// value extremes, with junk in the index fields of each load
		corner_vals = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
			32'h0000_0001, 32'h8000_0001, 32'h7FFF_FFFE, 32'h1234_5678};
		for (int i = 0; i < 8; i++)
			push_beat(REQ_LOAD, corner_vals[i], i == 7, 10'h3FF, 10'h2AA);
		live_count = 8;

		ask_span(0, 7);          // whole table
		ask_span(0, 0);          // single elements at both ends
		ask_span(7, 7);
		ask_span(1, 1);
		ask_span(2, 5);          // length-four spans, each covered exactly by one level-2 window
		ask_span(3, 6);
		ask_span(4, 3);          // empty span
		ask_span(0, 8);          // right at the count
		ask_span(1023, 1023);    // top index
		ask_span(0, 1023);

		// query while a batch is open must error, then the new batch replaces the old one
		push_beat(REQ_LOAD, 32'h7FFF_FFFF, 1'b0, '0, '0);
		push_beat(REQ_LOAD, 32'h8000_0000, 1'b0, '0, '0);
		ask_span(0, 0);
		push_beat(REQ_LOAD, 32'd5, 1'b1, '0, '0);
		live_count = 3;
		ask_span(0, 2);
		ask_span(2, 2);

		// hold off the sender until the engine has answered everything
		drain_results();

		// --- random ---
		base     = beats_sent;
		big_len  = 0;
		big_done = 1'b0;
		while (beats_sent - base < RANDOM_ITEMS) begin
			steady <= (beats_sent - base >= 150) && (beats_sent - base < 450);
			if (!big_done && beats_sent - base >= 500) begin
				// one full-size batch, overrunning the buffer so the tail loads are dropped
				big_done = 1'b1;
				big_len  = MAX_ELEMENTS + $urandom_range(1, 4);
				load_run(big_len, 1'b0);
				ask_span(0, MAX_ELEMENTS - 1);
				ask_span(MAX_ELEMENTS - 1, MAX_ELEMENTS - 1);
			end else begin
				case ($urandom_range(0, 7))
					0:       batch_len = 1;
					1:       batch_len = 2;
					2:       batch_len = 1 << $urandom_range(1, 6);
					3:       batch_len = (1 << $urandom_range(1, 6)) + 1;
					default: batch_len = $urandom_range(3, 48);
				endcase
				load_run(batch_len, $urandom_range(0, 3) == 0);
			end
			repeat ($urandom_range(6, 30)) ask_random_span();
		end

		// --- wind down ---
		drain_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("sparse_table_range_min_max test passed");
		else
			$display("sparse_table_range_min_max test failed");
		$finish;
	end

endmodule

[files.f]
src/stmm_pkg.sv
src/stmm_ctrl.sv
src/stmm_dp.sv
src/sparse_table_range_min_max.sv
tb/sv/span_minmax_checker.sv
tb/sv/testbench.sv
